>>> hw/rtl/calculator_lexer_defines.svh
// Assertion macros shared by the lexer modules.
// Each module that asserts must have clk and rst_n in scope.
`ifndef CALCULATOR_LEXER_DEFINES_SVH
`define CALCULATOR_LEXER_DEFINES_SVH

`ifndef SYNTHESIS

// Check a property on every rising clock edge outside reset.
`define CLEX_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("clex assertion failed");

// Check that a condition never holds outside reset.
`define CLEX_ASSERT_NEVER(lbl, cond) \
    `CLEX_ASSERT(lbl, !(cond))

`else

`define CLEX_ASSERT(lbl, prop)

`define CLEX_ASSERT_NEVER(lbl, cond)

`endif

`endif

>>> hw/rtl/clex_pkg.sv
package clex_pkg;

    // Accumulator width of the number mantissa.
    localparam int MANTISSA_BITS = 48;
    localparam int MANT_FIELD_W  = 48;
    localparam logic [MANTISSA_BITS-1:0] MANT_MAX = {MANTISSA_BITS{1'b1}};

    // Characters with special meaning.
    localparam logic [7:0] CH_NL   = 8'h0A;
    localparam logic [7:0] CH_SEMI = 8'h3B;
    localparam logic [7:0] CH_DOT  = 8'h2E;
    localparam logic [7:0] CH_ZERO = 8'h30;
    localparam logic [7:0] CH_NUL  = 8'h00;
    localparam logic [7:0] CH_PLUS = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_STAR = 8'h2A;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_LPAR = 8'h28;
    localparam logic [7:0] CH_RPAR = 8'h29;
    localparam logic [7:0] CH_EQ   = 8'h3D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB  = 8'h09;
    localparam logic [7:0] CH_VT   = 8'h0B;
    localparam logic [7:0] CH_FF   = 8'h0C;
    localparam logic [7:0] CH_CR   = 8'h0D;

    localparam logic [7:0]  FRAC_MAX = 8'hFF;
    localparam logic [15:0] ERR_MAX  = 16'hFFFF;

    // Result queue depth; a request may push two results at once.
    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    typedef enum logic [3:0] {
        KIND_NUMBER    = 4'd0,
        KIND_NAME_CHAR = 4'd1,
        KIND_NAME_END  = 4'd2,
        KIND_PLUS      = 4'd3,
        KIND_MINUS     = 4'd4,
        KIND_MUL       = 4'd5,
        KIND_DIV       = 4'd6,
        KIND_LPAREN    = 4'd7,
        KIND_RPAREN    = 4'd8,
        KIND_ASSIGN    = 4'd9,
        KIND_PRINT     = 4'd10,
        KIND_ERROR     = 4'd11
    } kind_t;

    typedef enum logic [1:0] {
        MODE_IDLE = 2'd0,
        MODE_NUM  = 2'd1,
        MODE_NAME = 2'd2
    } mode_t;

    typedef struct packed {
        kind_t                   kind;
        logic [7:0]              ch;
        logic [MANT_FIELD_W-1:0] mant;
        logic [7:0]              frac;
        logic                    ovf;
        logic [15:0]             err_count;
        logic                    last;
    } token_t;

    // Results produced by one request, in order.
    typedef struct packed {
        logic [1:0] count;
        token_t     first;
        token_t     second;
    } push_t;

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= CH_ZERO) && (c <= 8'h39);
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A));
    endfunction

    function automatic logic is_blank(input logic [7:0] c);
        return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_VT) ||
               (c == CH_FF) || (c == CH_CR);
    endfunction

    // Fit the accumulator to the mantissa field.
    function automatic logic [MANT_FIELD_W-1:0] mant_field(
        input logic [MANTISSA_BITS-1:0] acc
    );
        logic [63:0] w;
        w = 64'(acc);
        return w[MANT_FIELD_W-1:0];
    endfunction

endpackage

>>> hw/rtl/clex_core.sv
`include "calculator_lexer_defines.svh"

module clex_core
    import clex_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] char_in,
    input  logic       space_ok,
    output push_t      push
);

    localparam int WIDE_W = MANTISSA_BITS + 4;

    logic                     in_valid_reg, in_valid_next;
    logic [7:0]               in_char_reg;
    mode_t                    mode_reg, mode_next;
    logic [MANTISSA_BITS-1:0] acc_reg, acc_next;
    logic [7:0]               frac_reg, frac_next;
    logic                     dot_reg, dot_next;
    logic                     ovf_reg, ovf_next;
    logic [15:0]              bad_reg, bad_next;

    logic                     fire;
    logic [7:0]               c;
    logic                     c_digit, c_dot, c_numch, c_alpha, c_alnum;
    logic                     absorb_num, name_cont, closing;
    logic [MANTISSA_BITS-1:0] b_acc;
    logic [7:0]               b_frac;
    logic                     b_dot, b_ovf;
    logic [WIDE_W-1:0]        wide;
    logic [MANTISSA_BITS-1:0] a_acc;
    logic [7:0]               a_frac;
    logic                     a_dot, a_ovf;
    logic                     s_valid, s_err;
    kind_t                    s_kind;
    token_t                   close_tok, start_tok;

    // Hold one request at the input; take the next as this one moves on.
    assign fire          = in_valid_reg && space_ok;
    assign in_ready      = !in_valid_reg || space_ok;
    assign in_valid_next = in_ready ? in_valid : in_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            in_char_reg <= char_in;
        end
    end

    // Classify the held character.
    assign c       = in_char_reg;
    assign c_digit = is_digit(c);
    assign c_dot   = (c == CH_DOT);
    assign c_numch = c_digit || c_dot;
    assign c_alpha = is_alpha(c);
    assign c_alnum = c_alpha || c_digit;

    assign absorb_num = (mode_reg == MODE_NUM) && c_numch;
    assign name_cont  = (mode_reg == MODE_NAME) && c_alnum;
    assign closing    = ((mode_reg == MODE_NUM) && !c_numch) ||
                        ((mode_reg == MODE_NAME) && !c_alnum);

    // Add one digit or dot to the running number, or to a fresh one.
    always_comb
    begin
        b_acc  = absorb_num ? acc_reg  : '0;
        b_frac = absorb_num ? frac_reg : '0;
        b_dot  = absorb_num ? dot_reg  : 1'b0;
        b_ovf  = absorb_num ? ovf_reg  : 1'b0;
        wide   = (WIDE_W'(b_acc) << 3) + (WIDE_W'(b_acc) << 1) + WIDE_W'(c[3:0]);
        a_acc  = b_acc;
        a_frac = b_frac;
        a_dot  = b_dot;
        a_ovf  = b_ovf;
        if (c_dot)
        begin
            a_dot = 1'b1;
        end
        else
        begin
            if (wide[WIDE_W-1:MANTISSA_BITS] != '0)
            begin
                a_acc = MANT_MAX;
                a_ovf = 1'b1;
            end
            else
            begin
                a_acc = wide[MANTISSA_BITS-1:0];
            end
            if (b_dot && (b_frac != FRAC_MAX))
            begin
                a_frac = b_frac + 8'd1;
            end
        end
    end

    // Decode the character as the start of a new token.
    always_comb
    begin
        s_valid = 1'b1;
        s_err   = 1'b0;
        case (c)
            CH_PLUS:  s_kind = KIND_PLUS;
            CH_MINUS: s_kind = KIND_MINUS;
            CH_STAR:  s_kind = KIND_MUL;
            CH_SLASH: s_kind = KIND_DIV;
            CH_LPAR:  s_kind = KIND_LPAREN;
            CH_RPAR:  s_kind = KIND_RPAREN;
            CH_EQ:    s_kind = KIND_ASSIGN;
            CH_SEMI:  s_kind = KIND_PRINT;
            CH_NL:    s_kind = KIND_PRINT;
            CH_NUL:   s_kind = KIND_PRINT;
            default:
            begin
                if (is_blank(c) || c_numch)
                begin
                    s_kind  = KIND_ERROR;
                    s_valid = 1'b0;
                end
                else if (c_alpha)
                begin
                    s_kind = KIND_NAME_CHAR;
                end
                else
                begin
                    s_kind = KIND_ERROR;
                    s_err  = 1'b1;
                end
            end
        endcase
    end

    // Advance the lexer state.
    always_comb
    begin
        mode_next = mode_reg;
        acc_next  = acc_reg;
        frac_next = frac_reg;
        dot_next  = dot_reg;
        ovf_next  = ovf_reg;
        bad_next  = bad_reg;
        if (fire && !name_cont)
        begin
            if (absorb_num || c_numch)
            begin
                mode_next = MODE_NUM;
                acc_next  = a_acc;
                frac_next = a_frac;
                dot_next  = a_dot;
                ovf_next  = a_ovf;
            end
            else
            begin
                mode_next = c_alpha ? MODE_NAME : MODE_IDLE;
                acc_next  = '0;
                frac_next = '0;
                dot_next  = 1'b0;
                ovf_next  = 1'b0;
                if (s_err && (bad_reg != ERR_MAX))
                begin
                    bad_next = bad_reg + 16'd1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_IDLE;
            acc_reg  <= '0;
            frac_reg <= '0;
            dot_reg  <= 1'b0;
            ovf_reg  <= 1'b0;
            bad_reg  <= '0;
        end
        else
        begin
            mode_reg <= mode_next;
            acc_reg  <= acc_next;
            frac_reg <= frac_next;
            dot_reg  <= dot_next;
            ovf_reg  <= ovf_next;
            bad_reg  <= bad_next;
        end
    end

    // Build the closing token and the token that the character starts.
    always_comb
    begin
        close_tok           = '0;
        close_tok.ch        = c;
        close_tok.err_count = bad_reg;
        if (mode_reg == MODE_NUM)
        begin
            close_tok.kind = KIND_NUMBER;
            close_tok.mant = mant_field(acc_reg);
            close_tok.frac = frac_reg;
            close_tok.ovf  = ovf_reg;
        end
        else
        begin
            close_tok.kind = KIND_NAME_END;
        end

        start_tok           = '0;
        start_tok.kind      = name_cont ? KIND_NAME_CHAR : s_kind;
        start_tok.ch        = c;
        start_tok.err_count = bad_next;
    end

    // Order the results of this request and mark the final one.
    always_comb
    begin
        push        = '0;
        push.first  = start_tok;
        push.second = start_tok;
        if (fire && !absorb_num)
        begin
            if (name_cont)
            begin
                push.count      = 2'd1;
                push.first.last = 1'b1;
            end
            else if (closing)
            begin
                push.first = close_tok;
                if (s_valid)
                begin
                    push.count       = 2'd2;
                    push.second.last = 1'b1;
                end
                else
                begin
                    push.count      = 2'd1;
                    push.first.last = 1'b1;
                end
            end
            else if (s_valid)
            begin
                push.count      = 2'd1;
                push.first.last = 1'b1;
            end
        end
    end

    `CLEX_ASSERT(a_clear_outside_number,
        (mode_reg != MODE_NUM) |-> (acc_reg == '0 && frac_reg == '0 && !dot_reg && !ovf_reg))
    `CLEX_ASSERT(a_overflow_holds_max, ovf_reg |-> (acc_reg == MANT_MAX))
    `CLEX_ASSERT(a_fraction_needs_dot, (frac_reg != '0) |-> dot_reg)
    `CLEX_ASSERT(a_last_on_final,
        (push.count == 2'd2) |-> (!push.first.last && push.second.last))

endmodule

>>> hw/rtl/clex_outq.sv
`include "calculator_lexer_defines.svh"

module clex_outq
    import clex_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  push_t  push,
    output logic   space_ok,
    output logic   out_valid,
    input  logic   out_ready,
    output token_t head
);

    token_t              q_reg [QDEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]   cnt_reg, cnt_next;
    logic [QPTR_W-1:0]   wr_ptr_plus1;
    logic                pop;

    // Leave room for the two results one request may bring.
    assign space_ok  = (cnt_reg <= QCNT_W'(QDEPTH - 2));
    assign out_valid = (cnt_reg != '0);
    assign pop       = out_valid && out_ready;
    assign head      = q_reg[rd_ptr_reg];

    assign wr_ptr_plus1 = wr_ptr_reg + QPTR_W'(1);
    assign wr_ptr_next  = wr_ptr_reg + QPTR_W'(push.count);
    assign rd_ptr_next  = rd_ptr_reg + QPTR_W'(pop);
    assign cnt_next     = cnt_reg + QCNT_W'(push.count) - QCNT_W'(pop);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // Write up to two results in order.
    always_ff @(posedge clk)
    begin
        if (push.count != 2'd0)
        begin
            q_reg[wr_ptr_reg] <= push.first;
        end
        if (push.count == 2'd2)
        begin
            q_reg[wr_ptr_plus1] <= push.second;
        end
    end

    `CLEX_ASSERT(a_count_in_range, cnt_reg <= QCNT_W'(QDEPTH))
    `CLEX_ASSERT(a_push_needs_space, (push.count != 2'd0) |-> space_ok)
    `CLEX_ASSERT_NEVER(a_push_count_code, push.count == 2'd3)
    `CLEX_ASSERT(a_pointers_track_count,
        (cnt_reg == '0 || cnt_reg == QCNT_W'(QDEPTH)) |-> (wr_ptr_reg == rd_ptr_reg))

endmodule

>>> hw/rtl/calculator_lexer.sv
// Calculator lexer: takes one ASCII character per request and returns the
// tokens it causes, in order, with last set on the final token of each
// character. A character is taken every cycle as long as the result queue
// has room for two tokens; results leave at one per cycle while out_ready is
// high, so a stream in which each character causes at most one token runs at
// one character per cycle, and a character that both closes a number or name
// and starts a token puts two tokens in the queue. An accepted character
// passes through the input register, then the four-entry result queue,
// before its first token appears. Numbers carry a 48-bit decimal mantissa that
// saturates with an overflow flag, plus a count of digits after the dot.
module calculator_lexer
    import clex_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  char_in,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [3:0]  token_kind,
    output logic [7:0]  char_out,
    output logic [47:0] mantissa,
    output logic [7:0]  fraction_digits,
    output logic        mantissa_overflow,
    output logic [15:0] error_count,
    output logic        last
);

    push_t  push;
    logic   space_ok;
    token_t head;

    clex_core u_core (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .char_in  (char_in),
        .space_ok (space_ok),
        .push     (push)
    );

    clex_outq u_outq (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .space_ok  (space_ok),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .head      (head)
    );

    // Unpack the head token onto the result ports.
    assign token_kind        = head.kind;
    assign char_out          = head.ch;
    assign mantissa          = head.mant;
    assign fraction_digits   = head.frac;
    assign mantissa_overflow = head.ovf;
    assign error_count       = head.err_count;
    assign last              = head.last;

endmodule
